@@ rtl/replacement_selection_run_generator_core_macros.svh @@
// Assertion macros for the run generator checker.
`ifndef REPLACEMENT_SELECTION_RUN_GENERATOR_CORE_MACROS_SVH
`define REPLACEMENT_SELECTION_RUN_GENERATOR_CORE_MACROS_SVH

// Assertion on an explicit clock and an active-low disable.
`define RSRG_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Assertion on the block clock, disabled while the block is in reset.
`define RSRG_ASSERT(label, prop, msg) \
    `RSRG_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

@@ rtl/rsrg_pkg.sv @@
// Types and constants shared by the replacement-selection run generator.
`timescale 1ns / 1ps

package rsrg_pkg;

    // Default depth of the sorted cell chain.
    localparam int STORE_DEPTH_DEF = 32;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int CAP_W      = 6;
    localparam int RUN_W      = 16;
    localparam int KEY_W      = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RUNS = 1'd1;

    // Result kinds.
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_CLOSE  = 1'b1;

    // Saturation value of the run counter.
    localparam logic [RUN_W-1:0] RUN_MAX = '1;

    // Input item.
    typedef struct packed {
        logic signed [KEY_W-1:0] value;
        logic                    end_of_data;
    } in_t;

    // Result item.
    typedef struct packed {
        logic                    kind;
        logic signed [KEY_W-1:0] key_out;
        logic [RUN_W-1:0]        run_index;
        logic                    last;
    } out_t;

    // Contents of one chain cell.
    typedef struct packed {
        logic             valid;
        logic             mark;
        logic [KEY_W-1:0] key;
    } entry_t;

    // Operation broadcast to every cell in a cycle.
    typedef struct packed {
        logic insert;
        logic pop;
        logic clear_marks;
    } cell_op_t;

endpackage

@@ rtl/replacement_selection_run_generator_core.sv @@
// Top level of the replacement-selection run generator.
`timescale 1ns / 1ps
//
// Forms sorted runs from an unsorted key stream. Keys enter on the s_ channel
// (valid/ready); records and run-closed markers leave on the m_ channel, the
// last result caused by an item flagged by last. An item may cause no result.
// Write capacity and max_runs on the cfg port only while idle (not enforced).
//
// Keys live in a chain of STORE_DEPTH cells kept sorted by (mark, key), so
// the smallest unmarked key is always at the head. Each cycle the chain does
// one operation: insert, pop the head, or clear all marks on a run close.
// An item steps through accept, any services the full chain needs, insert,
// further services while the chain stays full or drains at end of data, and
// finish; each record or marker takes one service, returned or suppressed.
// Each result is held one transfer back until the next one is known; the
// final one moves to m_ at the item's finish, or later if m_ is stalled.
// A stalled receiver holds the output register; the chain then waits until
// the pending result can move on. s_ready is high only between items.
// Reset empties the chain, clears the run state and restores capacity 32
// and max_runs 65535.
//
module replacement_selection_run_generator_core #(
    parameter int STORE_DEPTH = rsrg_pkg::STORE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  rsrg_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output rsrg_pkg::out_t                    m_data,
    input  logic                              cfg_we,
    input  logic [rsrg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rsrg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int CW      = $clog2(STORE_DEPTH + 1);
    localparam int MAX_RES = STORE_DEPTH + 3;
    localparam int NW      = $clog2(MAX_RES + 1);
    localparam logic [CW-1:0] DEPTH_C   = CW'(STORE_DEPTH);
    localparam logic [NW-1:0] MAX_RES_C = NW'(MAX_RES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRE,
        ST_POST,
        ST_DONE
    } state_t;

    state_t                              state_reg;
    state_t                              state_next;
    logic [rsrg_pkg::KEY_W-1:0]          item_key_reg;
    logic                                item_end_reg;
    logic [CW-1:0]                       count_reg;
    logic [rsrg_pkg::CAP_W-1:0]          cap_reg;
    logic [rsrg_pkg::RUN_W-1:0]          max_runs_reg;
    logic [rsrg_pkg::KEY_W-1:0]          last_output_reg;
    logic [rsrg_pkg::RUN_W-1:0]          current_run_reg;
    logic                                nonempty_reg;
    logic [NW-1:0]                       nres_reg;
    logic                                pend_valid_reg;
    rsrg_pkg::out_t                      pend_reg;
    logic                                m_valid_reg;
    rsrg_pkg::out_t                      m_data_reg;

    logic [CW-1:0]                       cap_eff;
    logic                                full;
    logic                                out_free;
    logic                                can_service;
    logic                                need_post;
    logic                                do_service;
    logic                                do_insert;
    logic                                do_finish;
    logic                                do_flush;
    logic                                found;
    logic                                svc_keep;
    rsrg_pkg::out_t                      svc_result;
    rsrg_pkg::cell_op_t                  op;
    rsrg_pkg::entry_t                    new_entry;
    rsrg_pkg::entry_t                    head;
    rsrg_pkg::entry_t                    cell_q [STORE_DEPTH];
    logic                                gt [STORE_DEPTH];

    // Effective capacity: zero acts as one, oversize acts as the chain depth.
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CW'(1);
        end else if (int'(cap_reg) > STORE_DEPTH) begin
            cap_eff = DEPTH_C;
        end else begin
            cap_eff = CW'(cap_reg);
        end
    end

    assign full        = count_reg >= cap_eff;
    assign out_free    = !m_valid_reg || m_ready;
    assign can_service = !pend_valid_reg || out_free;
    assign head        = cell_q[0];
    assign found       = head.valid && !head.mark;

    // Result of one service: the head record, or a run-closed marker.
    always_comb begin
        svc_result.kind      = found ? rsrg_pkg::KIND_RECORD : rsrg_pkg::KIND_CLOSE;
        svc_result.key_out   = found ? $signed(head.key) : '0;
        svc_result.run_index = current_run_reg;
        svc_result.last      = 1'b0;
        svc_keep = (current_run_reg < max_runs_reg) && (nres_reg < MAX_RES_C);
    end

    // New key is marked when it does not exceed the last key output.
    always_comb begin
        new_entry.valid = 1'b1;
        new_entry.mark  = $signed(item_key_reg) <= $signed(last_output_reg);
        new_entry.key   = item_key_reg;
    end

    // Sequencer decisions for this cycle.
    always_comb begin
        need_post  = item_end_reg ? ((count_reg != '0) || nonempty_reg) : full;
        do_service = 1'b0;
        do_insert  = 1'b0;
        do_finish  = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PRE;
                end
            end
            ST_PRE: begin
                if (full) begin
                    do_service = can_service;
                end else begin
                    do_insert  = 1'b1;
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                if (need_post) begin
                    do_service = can_service;
                end else begin
                    do_finish  = 1'b1;
                    state_next = (pend_valid_reg && !out_free) ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE: begin
                state_next = out_free ? ST_IDLE : ST_DONE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        do_flush = ((state_reg == ST_POST && !need_post) || state_reg == ST_DONE)
                   && pend_valid_reg && out_free;
    end

    // Operation broadcast along the chain.
    always_comb begin
        op.insert      = do_insert;
        op.pop         = do_service && found;
        op.clear_marks = do_service && !found;
    end

    // Chain of sorted cells; each exchanges entries with its two neighbors.
    for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
        rsrg_pkg::entry_t left_e;
        rsrg_pkg::entry_t right_e;
        logic             left_g;

        if (i == 0) begin : g_head
            assign left_e = new_entry;
            assign left_g = 1'b0;
        end else begin : g_body
            assign left_e = cell_q[i-1];
            assign left_g = gt[i-1];
        end

        if (i == STORE_DEPTH - 1) begin : g_tail
            assign right_e = '0;
        end else begin : g_inner
            assign right_e = cell_q[i+1];
        end

        rsrg_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .op          (op),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .left_gt     (left_g),
            .right_entry (right_e),
            .gt          (gt[i]),
            .entry       (cell_q[i])
        );
    end

    // State, run bookkeeping, configuration and the result registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            item_key_reg    <= '0;
            item_end_reg    <= 1'b0;
            count_reg       <= '0;
            cap_reg         <= rsrg_pkg::CAP_W'(32);
            max_runs_reg    <= rsrg_pkg::RUN_MAX;
            last_output_reg <= '0;
            current_run_reg <= '0;
            nonempty_reg    <= 1'b0;
            nres_reg        <= '0;
            pend_valid_reg  <= 1'b0;
            pend_reg        <= '0;
            m_valid_reg     <= 1'b0;
            m_data_reg      <= '0;
        end else begin
            state_reg <= state_next;

            // Configuration writes.
            if (cfg_we) begin
                case (cfg_index)
                    rsrg_pkg::CFG_CAPACITY: cap_reg <= cfg_wdata[rsrg_pkg::CAP_W-1:0];
                    rsrg_pkg::CFG_MAX_RUNS: max_runs_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            // Input transfer.
            if (state_reg == ST_IDLE && s_valid) begin
                item_key_reg <= s_data.value;
                item_end_reg <= s_data.end_of_data;
                nres_reg     <= '0;
            end

            // Output register is loaded from the pending result, else drains
            // on a transfer.
            if ((do_service && svc_keep && pend_valid_reg) || do_flush) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (do_insert) begin
                count_reg <= count_reg + CW'(1);
            end

            // One service: pop the head record or close the run.
            if (do_service) begin
                if (found) begin
                    last_output_reg <= head.key;
                    nonempty_reg    <= 1'b1;
                    count_reg       <= count_reg - CW'(1);
                end else begin
                    if (current_run_reg != rsrg_pkg::RUN_MAX) begin
                        current_run_reg <= current_run_reg + rsrg_pkg::RUN_W'(1);
                    end
                    last_output_reg <= '0;
                    nonempty_reg    <= 1'b0;
                end
                if (svc_keep) begin
                    nres_reg       <= nres_reg + NW'(1);
                    pend_reg       <= svc_result;
                    pend_valid_reg <= 1'b1;
                    if (pend_valid_reg) begin
                        m_data_reg <= pend_reg;
                    end
                end
            end

            // End of data starts a fresh stream.
            if (do_finish && item_end_reg) begin
                current_run_reg <= '0;
                last_output_reg <= '0;
            end

            // Final result of the item leaves with last set.
            if (do_flush) begin
                m_data_reg     <= '{kind: pend_reg.kind, key_out: pend_reg.key_out,
                                    run_index: pend_reg.run_index, last: 1'b1};
                pend_valid_reg <= 1'b0;
            end
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/rsrg_cell.sv @@
// One cell of the sorted chain: holds one key and its mark bit.
`timescale 1ns / 1ps

module rsrg_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  rsrg_pkg::cell_op_t op,
    input  rsrg_pkg::entry_t  new_entry,
    input  rsrg_pkg::entry_t  left_entry,
    input  logic              left_gt,
    input  rsrg_pkg::entry_t  right_entry,
    output logic              gt,
    output rsrg_pkg::entry_t  entry
);

    logic                          valid_reg;
    logic                          valid_next;
    logic                          mark_reg;
    logic                          mark_next;
    logic [rsrg_pkg::KEY_W-1:0]    key_reg;
    logic [rsrg_pkg::KEY_W-1:0]    key_next;
    logic                          new_lt;

    // Order is (mark, key): unmarked keys sort ahead of marked ones.
    always_comb begin
        if (new_entry.mark != mark_reg) begin
            new_lt = !new_entry.mark;
        end else begin
            new_lt = $signed(new_entry.key) < $signed(key_reg);
        end
        gt = !valid_reg || new_lt;
    end

    // Pop shifts toward the head; insert shifts away from it past the slot.
    always_comb begin
        valid_next = valid_reg;
        mark_next  = mark_reg;
        key_next   = key_reg;
        if (op.pop) begin
            valid_next = right_entry.valid;
            mark_next  = right_entry.mark;
            key_next   = right_entry.key;
        end else if (op.insert && gt) begin
            if (left_gt) begin
                valid_next = left_entry.valid;
                mark_next  = left_entry.mark;
                key_next   = left_entry.key;
            end else begin
                valid_next = 1'b1;
                mark_next  = new_entry.mark;
                key_next   = new_entry.key;
            end
        end else if (op.clear_marks) begin
            mark_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            mark_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            mark_reg  <= mark_next;
        end
        key_reg <= key_next;
    end

    assign entry = '{valid: valid_reg, mark: mark_reg, key: key_reg};

endmodule

@@ rtl/rsrg_checker.sv @@
// Port-level checks for the run generator, bound to the top level.
`timescale 1ns / 1ps
`include "replacement_selection_run_generator_core_macros.svh"

module rsrg_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input rsrg_pkg::out_t                    m_data
);

    logic stalled;
    logic is_close;

    assign stalled  = m_valid && !m_ready;
    assign is_close = m_valid && (m_data.kind == rsrg_pkg::KIND_CLOSE);

    // A stalled result holds still until its transfer.
    `RSRG_ASSERT(a_out_hold, stalled |=> m_valid && $stable(m_data), "result changed while stalled")

    // Reset leaves no result on the output.
    `RSRG_ASSERT_CLK(a_reset_clears, aclk, 1'b1, !aresetn |=> !m_valid, "result valid after reset")

    // An accepted item is worked on before the next one is taken.
    `RSRG_ASSERT(a_one_item, s_valid && s_ready |=> !s_ready, "input taken during item work")

    // Run-closed markers carry a zero key.
    `RSRG_ASSERT(a_close_key, is_close |-> m_data.key_out == '0, "marker with nonzero key")

endmodule

bind replacement_selection_run_generator_core rsrg_checker u_rsrg_checker (.*);

@@ bench/replacement_selection_run_generator_core_tb.sv @@
// Self-checking testbench for the replacement-selection run generator core.
`timescale 1ns / 1ps

module replacement_selection_run_generator_core_tb;

    localparam int DEPTH                = rsrg_pkg::STORE_DEPTH_DEF;
    localparam int MAX_RESULTS_PER_ITEM = DEPTH + 3;
    localparam int SETTLE_CYCLES        = 48;
    localparam int QUIET_LIMIT          = 2000;
    localparam int IDLE_PCT             = 18;
    localparam int FALLING_ITEMS        = 20;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef enum int {KEYS_ANY, KEYS_NARROW, KEYS_RISING, KEYS_FALLING} key_mode_t;

    // One line of the directed stimulus table. n_typed < 0 means the
    // expected results come from the run model instead of the table.
    typedef struct {
        row_kind_t                                op;
        logic signed [rsrg_pkg::KEY_W-1:0]        value;
        logic                                     eod;
        logic [rsrg_pkg::CFG_IDX_W-1:0]           reg_idx;
        logic [rsrg_pkg::CFG_DATA_W-1:0]          reg_data;
        int                                       n_typed;
        rsrg_pkg::out_t                           typed_res [3];
    } stim_row_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    rsrg_pkg::in_t                   s_data;
    logic                            m_valid;
    logic                            m_ready;
    rsrg_pkg::out_t                  m_data;
    logic                            cfg_we;
    logic [rsrg_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rsrg_pkg::CFG_DATA_W-1:0] cfg_wdata;

    replacement_selection_run_generator_core #(
        .STORE_DEPTH(DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // Run model state: the held keys with their marks and the run bookkeeping.
    logic signed [rsrg_pkg::KEY_W-1:0] store_key  [DEPTH];
    logic                              store_mark [DEPTH];
    int                                store_fill;
    logic signed [rsrg_pkg::KEY_W-1:0] prev_key;
    logic [rsrg_pkg::RUN_W-1:0]        run_no;
    logic                              run_open;
    logic [rsrg_pkg::CAP_W-1:0]        cfg_cap;
    logic [rsrg_pkg::RUN_W-1:0]        cfg_max_runs;

    rsrg_pkg::out_t item_results[$];
    rsrg_pkg::out_t pending_results[$];
    stim_row_t      directed_rows[$];
    int             mismatches;
    int             quiet_cycles;
    bit             idle_on;

    // Clock: 8 ns period.
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // One output action: emit the smallest unmarked key, or close the run.
    function automatic void emit_next();
        int             best;
        logic           found;
        rsrg_pkg::out_t res;
        best  = 0;
        found = 1'b0;
        for (int i = 0; i < store_fill; i++) begin
            if (!store_mark[i] && (!found || store_key[i] < store_key[best])) begin
                best  = i;
                found = 1'b1;
            end
        end
        if (item_results.size() < MAX_RESULTS_PER_ITEM && run_no < cfg_max_runs) begin
            res.kind      = found ? rsrg_pkg::KIND_RECORD : rsrg_pkg::KIND_CLOSE;
            res.key_out   = found ? store_key[best] : '0;
            res.run_index = run_no;
            res.last      = 1'b0;
            item_results  = {item_results, res};
        end
        if (found) begin
            prev_key = store_key[best];
            run_open = 1'b1;
            store_fill--;
            store_key[best]  = store_key[store_fill];
            store_mark[best] = store_mark[store_fill];
        end else begin
            if (run_no != rsrg_pkg::RUN_MAX) run_no++;
            prev_key = '0;
            run_open = 1'b0;
            for (int i = 0; i < DEPTH; i++) store_mark[i] = 1'b0;
        end
    endfunction

    // Works out every result that one accepted key causes.
    function automatic void form_runs_step(rsrg_pkg::in_t it);
        int                                eff_cap;
        logic signed [rsrg_pkg::KEY_W-1:0] key;
        key     = it.value;
        eff_cap = cfg_cap;
        if (eff_cap < 1) eff_cap = 1;
        if (eff_cap > DEPTH) eff_cap = DEPTH;
        item_results.delete();

        while (store_fill >= eff_cap) emit_next();
        if (store_fill < DEPTH) begin
            store_key[store_fill]  = key;
            store_mark[store_fill] = (key <= prev_key);
            store_fill++;
        end

        // End of data drains the store and starts the next stream at run zero.
        if (it.end_of_data) begin
            while (store_fill > 0 || run_open) emit_next();
            run_no   = '0;
            prev_key = '0;
        end else begin
            while (store_fill >= eff_cap) emit_next();
        end

        if (item_results.size() > 0) item_results[item_results.size() - 1].last = 1'b1;
    endfunction

    function automatic rsrg_pkg::out_t record_res(logic signed [rsrg_pkg::KEY_W-1:0] k,
                                                  int run, logic l);
        rsrg_pkg::out_t r;
        r.kind      = rsrg_pkg::KIND_RECORD;
        r.key_out   = k;
        r.run_index = rsrg_pkg::RUN_W'(run);
        r.last      = l;
        return r;
    endfunction

    function automatic rsrg_pkg::out_t close_res(int run, logic l);
        rsrg_pkg::out_t r;
        r.kind      = rsrg_pkg::KIND_CLOSE;
        r.key_out   = '0;
        r.run_index = rsrg_pkg::RUN_W'(run);
        r.last      = l;
        return r;
    endfunction

    function automatic stim_row_t item_row(logic signed [rsrg_pkg::KEY_W-1:0] v, logic e,
                                           int n = -1, rsrg_pkg::out_t r0 = '0,
                                           rsrg_pkg::out_t r1 = '0, rsrg_pkg::out_t r2 = '0);
        stim_row_t row;
        row.op           = ROW_ITEM;
        row.value        = v;
        row.eod          = e;
        row.reg_idx      = '0;
        row.reg_data     = '0;
        row.n_typed      = n;
        row.typed_res[0] = r0;
        row.typed_res[1] = r1;
        row.typed_res[2] = r2;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(logic [rsrg_pkg::CFG_IDX_W-1:0] idx,
                                          logic [rsrg_pkg::CFG_DATA_W-1:0] data);
        stim_row_t row;
        row          = item_row('0, 1'b0, 0);
        row.op       = ROW_CFG;
        row.reg_idx  = idx;
        row.reg_data = data;
        return row;
    endfunction

    // Appends one line to the directed table.
    function automatic void append_row(stim_row_t row);
        directed_rows = {directed_rows, row};
    endfunction

    // Offers one key, waits for its transfer and queues what it causes.
    task automatic transfer_item(rsrg_pkg::in_t it, bit predicted = 1'b1);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        form_runs_step(it);
        if (predicted) begin
            pending_results = {pending_results, item_results};
        end
    endtask

    // Holds the sender until every expected result has come and the core is idle.
    task automatic settle_block();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [rsrg_pkg::CFG_IDX_W-1:0] idx,
                             logic [rsrg_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == rsrg_pkg::CFG_CAPACITY) cfg_cap = data[rsrg_pkg::CAP_W-1:0];
        else cfg_max_runs = data[rsrg_pkg::RUN_W-1:0];
        @(negedge aclk);
    endtask

    // Random streams: mostly well-formed runs ending in end of data, with
    // stray end-of-data flags and unterminated streams as noise.
    task automatic random_items(int count);
        int                                sent;
        int                                span;
        key_mode_t                         mode;
        logic signed [rsrg_pkg::KEY_W-1:0] walk;
        rsrg_pkg::in_t                     it;
        sent = 0;
        while (sent < count) begin
            span = $urandom_range(1, 40);
            mode = key_mode_t'($urandom_range(0, 3));
            walk = $urandom;
            for (int j = 0; j < span && sent < count; j++) begin
                case (mode)
                    KEYS_ANY: it.value = $urandom;
                    KEYS_NARROW: it.value = int'($urandom_range(0, 16)) - 8;
                    KEYS_RISING: begin
                        walk     = walk + $urandom_range(0, 50);
                        it.value = walk;
                    end
                    default: begin
                        walk     = walk - $urandom_range(0, 50);
                        it.value = walk;
                    end
                endcase
                if (j == span - 1) it.end_of_data = ($urandom_range(0, 99) < 85);
                else it.end_of_data = ($urandom_range(0, 99) < 3);
                transfer_item(it);
                sent++;
            end
        end
    endtask

    // Receiver stalls at random while idling is enabled.
    always @(negedge aclk) begin
        m_ready <= idle_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
    end

    // Result checking and the no-progress watchdog.
    always @(posedge aclk) begin
        rsrg_pkg::out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result kind %0d key %0d run %0d last %0d",
                             $time, m_data.kind, m_data.key_out, m_data.run_index,
                             m_data.last);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.kind !== want.kind || m_data.key_out !== want.key_out ||
                        m_data.run_index !== want.run_index || m_data.last !== want.last) begin
                        $display("%0t: expected kind %0d key %0d run %0d last %0d, got %s",
                                 $time, want.kind, want.key_out, want.run_index, want.last,
                                 $sformatf("kind %0d key %0d run %0d last %0d",
                                           m_data.kind, m_data.key_out,
                                           m_data.run_index, m_data.last));
                        mismatches++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        rsrg_pkg::in_t                     it;
        logic signed [rsrg_pkg::KEY_W-1:0] walk;
        int                                phase_cap  [8];
        int                                phase_runs [8];

        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        aresetn      = 1'b0;
        idle_on      = 1'b1;
        mismatches   = 0;
        quiet_cycles = 0;

        // Model state after reset.
        for (int i = 0; i < DEPTH; i++) begin
            store_key[i]  = '0;
            store_mark[i] = 1'b0;
        end
        store_fill   = 0;
        prev_key     = '0;
        run_no       = '0;
        run_open     = 1'b0;
        cfg_cap      = rsrg_pkg::CAP_W'(32);
        cfg_max_runs = rsrg_pkg::RUN_MAX;

        // Directed table: reset defaults, key extremes, marking at zero,
        // capacity clamping, capacity lowered below the fill and suppression.
        append_row(item_row(32'sd7, 1'b1, 2,
                            record_res(32'sd7, 0, 1'b0), close_res(0, 1'b1)));
        append_row(item_row(-32'sd3, 1'b1, 3, close_res(0, 1'b0),
                            record_res(-32'sd3, 1, 1'b0), close_res(1, 1'b1)));
        append_row(item_row(32'sd0, 1'b1, 3, close_res(0, 1'b0),
                            record_res(32'sd0, 1, 1'b0), close_res(1, 1'b1)));
        append_row(item_row(32'sh7FFF_FFFF, 1'b1, 2,
                            record_res(32'sh7FFF_FFFF, 0, 1'b0),
                            close_res(0, 1'b1)));
        append_row(item_row(32'sh8000_0000, 1'b1, 3, close_res(0, 1'b0),
                            record_res(32'sh8000_0000, 1, 1'b0),
                            close_res(1, 1'b1)));
        append_row(item_row(32'sd100, 1'b0, 0));
        append_row(item_row(-32'sd100, 1'b0, 0));
        append_row(item_row(32'sd50, 1'b1));
        append_row(cfg_row(rsrg_pkg::CFG_CAPACITY, 16'd1));
        append_row(item_row(32'sd10, 1'b0, 1, record_res(32'sd10, 0, 1'b1)));
        append_row(item_row(32'sd20, 1'b0, 1, record_res(32'sd20, 0, 1'b1)));
        append_row(item_row(32'sd5, 1'b0, 2, close_res(0, 1'b0),
                            record_res(32'sd5, 1, 1'b1)));
        append_row(item_row(32'sd5, 1'b1, 3, close_res(1, 1'b0),
                            record_res(32'sd5, 2, 1'b0), close_res(2, 1'b1)));
        append_row(cfg_row(rsrg_pkg::CFG_CAPACITY, 16'd0));
        append_row(item_row(32'sd3, 1'b0));
        append_row(item_row(-32'sd1, 1'b0));
        append_row(cfg_row(rsrg_pkg::CFG_CAPACITY, 16'd63));
        append_row(item_row(32'sd40, 1'b0));
        append_row(item_row(-32'sd40, 1'b0));
        append_row(item_row(32'sd1, 1'b0));
        append_row(cfg_row(rsrg_pkg::CFG_CAPACITY, 16'd2));
        append_row(item_row(32'sd7, 1'b0));
        append_row(cfg_row(rsrg_pkg::CFG_MAX_RUNS, 16'd1));
        append_row(item_row(-32'sd5, 1'b1));
        append_row(cfg_row(rsrg_pkg::CFG_MAX_RUNS, 16'd0));
        append_row(item_row(32'sd5, 1'b1, 0));
        append_row(cfg_row(rsrg_pkg::CFG_MAX_RUNS, 16'hFFFF));
        append_row(cfg_row(rsrg_pkg::CFG_CAPACITY, 16'd32));

        phase_cap  = '{3, 32, 1, 63, 7, 0, 16, 0};
        phase_runs = '{65535, 2, 65535, 65535, 1, 65535, 0, 0};

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Walk the directed table.
        foreach (directed_rows[r]) begin
            if (directed_rows[r].op == ROW_CFG) begin
                settle_block();
                write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_data);
            end else begin
                it.value       = directed_rows[r].value;
                it.end_of_data = directed_rows[r].eod;
                transfer_item(it, directed_rows[r].n_typed < 0);
                for (int k = 0; k < directed_rows[r].n_typed; k++)
                    pending_results = {pending_results, directed_rows[r].typed_res[k]};
            end
        end

        // Random phases, each under its own register setting. The store is
        // not drained between phases, so lowering capacity trims a full store.
        for (int p = 0; p < 8; p++) begin
            settle_block();
            write_reg(rsrg_pkg::CFG_CAPACITY,
                      rsrg_pkg::CFG_DATA_W'((p == 7) ? $urandom_range(1, DEPTH)
                                                     : phase_cap[p]));
            write_reg(rsrg_pkg::CFG_MAX_RUNS,
                      rsrg_pkg::CFG_DATA_W'((p == 7) ? $urandom_range(1, 8)
                                                     : phase_runs[p]));
            if (p == 3) idle_on = 1'b0;
            if (p == 2) begin
                random_items(25);
                settle_block();
                random_items(25);
            end else begin
                random_items(50);
            end
            idle_on = 1'b1;
        end

        // Falling keys at capacity one close a run per key.
        settle_block();
        write_reg(rsrg_pkg::CFG_CAPACITY, 16'd1);
        write_reg(rsrg_pkg::CFG_MAX_RUNS, 16'hFFFF);
        idle_on = 1'b0;
        walk    = 32'sh7FFF_FFFF;
        for (int i = 0; i < FALLING_ITEMS; i++) begin
            it.value       = walk;
            it.end_of_data = 1'b0;
            transfer_item(it);
            walk = walk - $urandom_range(0, 1000);
        end
        it.value       = walk;
        it.end_of_data = 1'b1;
        transfer_item(it);
        idle_on = 1'b1;

        // A fresh stream after end of data starts again from run zero.
        settle_block();
        write_reg(rsrg_pkg::CFG_CAPACITY, rsrg_pkg::CFG_DATA_W'($urandom_range(1, DEPTH)));
        random_items(40);

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
